// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is low
`define SBDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that post holds in the cycle after pre, switched off while reset is low
`define SBDA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/sbda_pkg.sv
// constants and types shared by the decimal text converter files
package sbda_pkg;

  // fixed width of the value field and of one character
  localparam int ValueBits = 64;
  localparam int CharBits  = 8;

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [CharBits-1:0]  char_t;
  typedef logic [3:0]           bcd_digit_t;

  // ascii codes
  localparam char_t DIGIT_BASE = 8'd48;
  localparam char_t MINUS_CHAR = 8'd45;
  localparam char_t DIGIT_NINE = 8'd57;

  // double dabble correction
  localparam bcd_digit_t DABBLE_LIMIT = 4'd5;
  localparam bcd_digit_t DABBLE_ADD   = 4'd3;

endpackage

// File: rtl/sbda_if.sv
// handshake channels for the decimal text converter
interface sbda_in_if
  import sbda_pkg::*;
();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if
  import sbda_pkg::*;
();
  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: rtl/signed_binary_to_decimal_ascii_unit.sv
// signed binary to decimal ascii converter, iterative double dabble
//
//   channel | dir | payload                  | item
//   in_i    | in  | value[63:0]              | one signed number
//   out_o   | out | text_char[7:0], last_char| one character
//
// one item goes through an accept, VALUE_WIDTH shifts in the double dabble
// unit, a pass that drops leading zero digits, then one character sent at a
// time, a minus sign first for a negative value.
// in_i.ready is high only while the sequencer is idle.
// rst_ni clears the sequencer and the output valid; no clearing pass.
// a stalled out_o holds the character and pauses the sequencer while it sends.
module signed_binary_to_decimal_ascii_unit
  import sbda_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbda_in_if.sink     in_i,
  sbda_out_if.source  out_o
);

`include "assert_macros.svh"

  // enough bcd digits for any magnitude up to 2^VALUE_WIDTH - 1
  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BcdW      = 4 * NumDigits;
  localparam int BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]             state_q, state_d;
  logic [BitCntW-1:0]     bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]     dig_cnt_q, dig_cnt_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic                   out_valid_q, out_valid_d;
  char_t                  text_char_q, text_char_d;
  logic                   last_char_q, last_char_d;

  logic [VALUE_WIDTH-1:0] in_bits;
  logic                   in_neg;
  logic [BcdW-1:0]        bcd_adj;
  bcd_digit_t             top_digit;
  logic                   out_free;
  logic                   in_take;

  // magnitude of the incoming value, most negative value wraps to 2^(w-1)
  assign in_bits   = in_i.value[VALUE_WIDTH-1:0];
  assign in_neg    = in_bits[VALUE_WIDTH-1];
  assign in_take   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign out_free  = !out_valid_q || out_o.ready;

  // add-3 correction on every digit before the shift
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= DABBLE_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + DABBLE_ADD;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    out_valid_d = out_valid_q;
    text_char_d = text_char_q;
    last_char_d = last_char_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          neg_d     = in_neg;
          mag_d     = in_neg ? (~in_bits + 1'b1) : in_bits;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(VALUE_WIDTH);
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d     = {bcd_adj[BcdW-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == BitCntW'(1)) begin
          dig_cnt_d = DigCntW'(NumDigits);
          state_d   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == '0 && dig_cnt_q != DigCntW'(1)) begin
          bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            text_char_d = MINUS_CHAR;
            last_char_d = 1'b0;
            neg_d       = 1'b0;
          end else begin
            text_char_d = DIGIT_BASE + {4'd0, top_digit};
            last_char_d = (dig_cnt_q == DigCntW'(1));
            bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
            dig_cnt_d   = dig_cnt_q - 1'b1;
            if (dig_cnt_q == DigCntW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      neg_q       <= neg_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    bcd_q       <= bcd_d;
    text_char_q <= text_char_d;
    last_char_q <= last_char_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = text_char_q;
  assign out_o.last_char = last_char_q;

  // checks
  `SBDA_ASSERT(a_minus_not_last,
    (out_o.valid && out_o.text_char == MINUS_CHAR) |-> !out_o.last_char,
    "minus sign marked as last character")
  `SBDA_ASSERT(a_char_legal,
    out_o.valid |-> (out_o.text_char == MINUS_CHAR ||
      (out_o.text_char >= DIGIT_BASE && out_o.text_char <= DIGIT_NINE)),
    "character is neither digit nor minus")
  `SBDA_ASSERT_NEXT(a_take_starts_conv, in_take, state_q == ST_CONV,
    "accepted item did not start conversion")
  `SBDA_ASSERT(a_conv_count,
    (state_q == ST_CONV) |-> (bit_cnt_q != '0),
    "shift counter empty during conversion")
  `SBDA_ASSERT(a_digit_count,
    (state_q == ST_SKIP || state_q == ST_EMIT) |-> (dig_cnt_q != '0),
    "digit counter empty while sending")

endmodule

// File: tb/sv/signed_binary_to_decimal_ascii_unit_test.sv
// self-checking testbench for the signed binary to decimal ascii converter
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_unit_test;
  import sbda_pkg::*;

  localparam int HalfPeriod   = 6;
  localparam int ResetCycles  = 8;
  localparam int ItemsPerLeg  = 53;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 200;
  localparam int NumDirected  = 22;

  // one expected character of the decimal text
  typedef struct packed {
    char_t text_char;
    logic  last_char;
  } text_char_t;

  // directed row: value and, where obvious, its text typed in
  typedef struct {
    value_t value;
    string  text;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbda_in_if  num_ch ();
  sbda_out_if text_ch ();

  text_char_t text_due_q [$];
  string      typed_text_q [$];
  int         mismatch_count = 0;
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         hold_req = 1'b0;
  bit         hold_taken = 1'b0;
  int         hold_left = 0;

  directed_row_t directed_rows [NumDirected] = '{
    '{64'd0,                    "0"},
    '{64'd1,                    ""},
    '{-64'sd1,                  "-1"},
    '{64'd9,                    ""},
    '{-64'sd9,                  ""},
    '{64'd10,                   ""},
    '{64'd99,                   ""},
    '{64'd100,                  ""},
    '{-64'sd100,                ""},
    '{64'd12345,                ""},
    '{64'h7FFF_FFFF_FFFF_FFFF,  "9223372036854775807"},
    '{64'h8000_0000_0000_0000,  "-9223372036854775808"},
    '{64'h8000_0000_0000_0001,  ""},
    '{64'h7FFF_FFFF_FFFF_FFFE,  ""},
    '{64'd1000000000000000000,  ""},
    '{64'd999999999999999999,   ""},
    '{-64'sd1000000000000000000, ""},
    '{64'h0000_0000_FFFF_FFFF,  ""},
    '{64'h5555_5555_5555_5555,  ""},
    '{64'hAAAA_AAAA_AAAA_AAAA,  ""},
    '{64'hFFFF_FFFF_0000_0000,  ""},
    '{-64'sd10,                 ""}
  };

  signed_binary_to_decimal_ascii_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_ch),
    .out_o  (text_ch)
  );

  // clock
  always #HalfPeriod clk_i = ~clk_i;

  // run limit
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // expected text of a signed value, most significant digit first
  task automatic queue_decimal_text(input value_t num);
    logic       negative;
    value_t     mag;
    bcd_digit_t digs [20];
    int         nd;
    text_char_t tc;
    negative = num[ValueBits-1];
    mag = negative ? (~num + 64'd1) : num;
    nd = 0;
    do begin
      digs[nd] = bcd_digit_t'(mag % 64'd10);
      mag = mag / 64'd10;
      nd++;
    end while (mag != 0);
    if (negative) begin
      tc.text_char = MINUS_CHAR;
      tc.last_char = 1'b0;
      text_due_q.push_back(tc);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      tc.text_char = DIGIT_BASE + char_t'(digs[k]);
      tc.last_char = (k == 0);
      text_due_q.push_back(tc);
    end
  endtask

  // expected text given literally
  task automatic queue_typed_text(input string txt);
    text_char_t tc;
    for (int i = 0; i < txt.len(); i++) begin
      tc.text_char = char_t'(txt[i]);
      tc.last_char = (i == txt.len() - 1);
      text_due_q.push_back(tc);
    end
  endtask

  // random value, spread over lengths, signs and digit boundaries
  function automatic value_t random_value();
    int     kind;
    int     nbits;
    value_t mag;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: mag = {$urandom, $urandom};
      4, 5, 6: begin
        nbits = $urandom_range(1, 63);
        mag = {$urandom, $urandom} >> (64 - nbits);
        if ($urandom_range(1) == 1) mag = -mag;
      end
      7: begin
        mag = 64'd1;
        repeat ($urandom_range(18)) mag = mag * 64'd10;
        mag = mag - 64'd1 + value_t'($urandom_range(2));
        if ($urandom_range(1) == 1) mag = -mag;
      end
      8: begin
        case ($urandom_range(3))
          0: mag = 64'h8000_0000_0000_0000;
          1: mag = 64'h7FFF_FFFF_FFFF_FFFF;
          2: mag = '0;
          default: mag = '1;
        endcase
      end
      default: begin
        mag = value_t'($urandom_range(999));
        if ($urandom_range(1) == 1) mag = -mag;
      end
    endcase
    return mag;
  endfunction

  // offer one number, leaving valid high on return
  task automatic send_number(input value_t num, input string txt);
    while ($urandom_range(99) < tx_idle_pct) begin
      num_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    typed_text_q.push_back(txt);
    num_ch.valid <= 1'b1;
    num_ch.value <= num;
    do @(posedge clk_i); while (!num_ch.ready);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every expected character
  task automatic drain_text();
    num_ch.valid <= 1'b0;
    while (text_due_q.size() != 0 || typed_text_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, or a long counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HoldCycles;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      text_ch.ready <= 1'b0;
    end else begin
      text_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // predict on accepted numbers, check accepted characters
  always @(posedge clk_i) begin : accept_and_check
    string      txt;
    text_char_t due;
    if (rst_ni && num_ch.valid && num_ch.ready) begin
      if (typed_text_q.size() == 0) begin
        report_mismatch("number accepted while none was offered");
        queue_decimal_text(num_ch.value);
      end else begin
        txt = typed_text_q.pop_front();
        if (txt.len() > 0) queue_typed_text(txt);
        else queue_decimal_text(num_ch.value);
      end
    end
    if (rst_ni && text_ch.valid && text_ch.ready) begin
      if (text_due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d", text_ch.text_char));
      end else begin
        due = text_due_q.pop_front();
        if (text_ch.text_char !== due.text_char)
          report_mismatch($sformatf("text_char %0d, expected %0d",
                                    text_ch.text_char, due.text_char));
        if (text_ch.last_char !== due.last_char)
          report_mismatch($sformatf("last_char %b, expected %b on character %0d",
                                    text_ch.last_char, due.last_char, due.text_char));
      end
    end
  end

  // stimulus and verdict
  initial begin
    num_ch.valid  = 1'b0;
    num_ch.value  = '0;
    rst_ni        = 1'b0;
    tx_idle_pct   = 22;
    rx_idle_pct   = 61;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (int i = 0; i < NumDirected; i++)
      send_number(directed_rows[i].value, directed_rows[i].text);

    // random legs with changing idle ratios
    for (int leg = 0; leg < 3; leg++) begin
      drain_text();
      case (leg)
        0: begin tx_idle_pct = 22; rx_idle_pct = 61; end
        1: begin tx_idle_pct = 61; rx_idle_pct = 22; hold_req = 1'b1; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < ItemsPerLeg; n++) send_number(random_value(), "");
    end

    // let the last text come out, then settle
    drain_text();
    repeat (SettleCycles) @(posedge clk_i);
    if (text_due_q.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", text_due_q.size()));
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sbda_pkg.sv
rtl/sbda_if.sv
rtl/signed_binary_to_decimal_ascii_unit.sv
tb/sv/signed_binary_to_decimal_ascii_unit_test.sv
